>>> hw/rtl/rbdq_pkg.sv
// ----------------------------------------------------------------------------
// rbdq_pkg
// shared constants, codes and types of the circular indexed deque
// ----------------------------------------------------------------------------
package rbdq_pkg;

   // default sizing
   localparam int unsigned CAPACITY_DEFAULT   = 16;
   localparam int unsigned DATA_WIDTH_DEFAULT = 8;

   // request operation codes
   typedef logic [1:0] op_type;
   localparam op_type OP_GET    = 2'd0;
   localparam op_type OP_SET    = 2'd1;
   localparam op_type OP_INSERT = 2'd2;
   localparam op_type OP_REMOVE = 2'd3;

   // response status codes
   typedef logic [1:0] status_type;
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_RANGE = 2'd2;

endpackage

>>> hw/rtl/ring_buffer_indexed_deque.sv
// ----------------------------------------------------------------------------
// ring_buffer_indexed_deque
// fixed-capacity circular deque with get, set, insert and remove by position
// ----------------------------------------------------------------------------
// One request is handled at a time; req_ready is high only while the
// sequencer is idle, and a finished response sits in an output register so
// that the next request can be taken while it waits. Logical position p
// lives in slot (head + p) mod CAPACITY, computed by the single slot mapping
// unit that every memory access goes through. An insert or remove moves the
// elements of one side of the deque one element at a time: the front side
// when the position is below half the count, else the back side. Each moved
// element passes through a test, a memory read and a memory write. At most
// CAPACITY/2 elements are moved for an insert and CAPACITY/2 - 1 for a
// remove when CAPACITY is even. A get reads the element after its range
// check; a rejected request goes from the check to the output register.
// The element store needs no clearing after reset: only slots that hold live
// elements are ever read.
// ----------------------------------------------------------------------------
module ring_buffer_indexed_deque #(
   parameter int unsigned CAPACITY   = rbdq_pkg::CAPACITY_DEFAULT,
   parameter int unsigned DATA_WIDTH = rbdq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  rbdq_pkg::op_type                 req_op,
   input  logic [$clog2(CAPACITY+1)-1:0]    req_index,
   input  logic [DATA_WIDTH-1:0]            req_value,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [DATA_WIDTH-1:0]            rsp_read_value,
   output rbdq_pkg::status_type             rsp_status,
   output logic [$clog2(CAPACITY+1)-1:0]    rsp_count
);
   import rbdq_pkg::*;

   // position / count width and slot width
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned SW = CW + 1;

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;   // waiting for a request
   localparam logic [2:0] S_CHECK = 3'd1;   // range checks and move setup
   localparam logic [2:0] S_TEST  = 3'd2;   // move loop done?
   localparam logic [2:0] S_READ  = 3'd3;   // read the source element
   localparam logic [2:0] S_MOVE  = 3'd4;   // write it to the destination
   localparam logic [2:0] S_WRVAL = 3'd5;   // write the request value
   localparam logic [2:0] S_GETRD = 3'd6;   // read for a get
   localparam logic [2:0] S_DONE  = 3'd7;   // hand result to the output register

   logic [2:0]            state_ff, state_in;
   op_type                op_ff, op_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         dst_ff, dst_in;        // destination position of a move
   logic [CW-1:0]         end_ff, end_in;        // position where the move loop stops
   logic                  up_ff, up_in;          // source lies above destination
   logic                  low_ff, low_in;        // front side is the one moved
   status_type            status_ff, status_in;
   logic                  rd_ok_ff, rd_ok_in;    // successful get
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_read_value_ff, rsp_read_value_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [CW-1:0]         rsp_count_ff, rsp_count_in;
   logic [DATA_WIDTH-1:0] mem_rd_ff;

   // element store
   logic [DATA_WIDTH-1:0] mem [CAPACITY];

   logic [CW-1:0]         src_pos;
   logic [CW-1:0]         pos_sel;
   logic [SW-1:0]         slot_sum;
   logic [SW-1:0]         slot_wrap;
   logic [AW-1:0]         slot;
   logic                  mem_we;
   logic [DATA_WIDTH-1:0] mem_wdata;
   logic                  req_fire;
   logic                  rsp_load;
   logic [CW-1:0]         half_count;

   // ---------------------------------------------------------------------
   // shared slot mapping unit: (head + position) mod CAPACITY
   // head < CAPACITY and position <= CAPACITY, so one conditional subtract
   // ---------------------------------------------------------------------
   assign src_pos   = up_ff ? (dst_ff + CW'(1)) : (dst_ff - CW'(1));
   assign pos_sel   = (state_ff == S_READ) ? src_pos : dst_ff;
   assign slot_sum  = SW'(head_ff) + SW'(pos_sel);
   assign slot_wrap = (slot_sum >= SW'(CAPACITY)) ? (slot_sum - SW'(CAPACITY)) : slot_sum;
   assign slot      = slot_wrap[AW-1:0];

   // memory write: a moved element or the request value
   assign mem_we    = (state_ff == S_MOVE) || (state_ff == S_WRVAL);
   assign mem_wdata = (state_ff == S_MOVE) ? mem_rd_ff : val_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[slot] <= mem_wdata;
      end
      if ((state_ff == S_READ) || (state_ff == S_GETRD)) begin
         mem_rd_ff <= mem[slot];
      end
   end

   // handshakes
   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign half_count = count_ff >> 1;

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in          = state_ff;
      op_in             = op_ff;
      idx_in            = idx_ff;
      val_in            = val_ff;
      head_in           = head_ff;
      count_in          = count_ff;
      dst_in            = dst_ff;
      end_in            = end_ff;
      up_in             = up_ff;
      low_in            = low_ff;
      status_in         = status_ff;
      rd_ok_in          = rd_ok_ff;
      rsp_read_value_in = rsp_read_value_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_count_in      = rsp_count_ff;
      rsp_valid_in      = rsp_ready ? 1'b0 : rsp_valid_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in     = req_op;
               idx_in    = req_index;
               val_in    = req_value;
               status_in = ST_OK;
               rd_ok_in  = 1'b0;
               state_in  = S_CHECK;
            end
         end

         S_CHECK: begin
            unique case (op_ff)
               OP_GET: begin
                  if (idx_ff < count_ff) begin
                     dst_in   = idx_ff;
                     rd_ok_in = 1'b1;
                     state_in = S_GETRD;
                  end else begin
                     status_in = ST_RANGE;
                     state_in  = S_DONE;
                  end
               end
               OP_SET: begin
                  // no moves: the loop test falls straight through to the write
                  if (idx_ff < count_ff) begin
                     dst_in   = idx_ff;
                     end_in   = idx_ff;
                     state_in = S_TEST;
                  end else begin
                     status_in = ST_RANGE;
                     state_in  = S_DONE;
                  end
               end
               OP_INSERT: begin
                  if (count_ff >= CW'(CAPACITY)) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else if (idx_ff > count_ff) begin
                     status_in = ST_RANGE;
                     state_in  = S_DONE;
                  end else begin
                     end_in   = idx_ff;
                     state_in = S_TEST;
                     if (idx_ff < half_count) begin
                        // head steps back, front elements shift toward it
                        low_in  = 1'b1;
                        head_in = (head_ff == '0) ? AW'(CAPACITY - 1) : (head_ff - AW'(1));
                        dst_in  = '0;
                        up_in   = 1'b1;
                     end else begin
                        // tail elements shift toward the tail
                        low_in  = 1'b0;
                        dst_in  = count_ff;
                        up_in   = 1'b0;
                     end
                  end
               end
               OP_REMOVE: begin
                  if (idx_ff < count_ff) begin
                     dst_in   = idx_ff;
                     state_in = S_TEST;
                     if (idx_ff < half_count) begin
                        low_in = 1'b1;
                        end_in = '0;
                        up_in  = 1'b0;
                     end else begin
                        low_in = 1'b0;
                        end_in = count_ff - CW'(1);
                        up_in  = 1'b1;
                     end
                  end else begin
                     status_in = ST_RANGE;
                     state_in  = S_DONE;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         S_TEST: begin
            if (dst_ff == end_ff) begin
               if (op_ff == OP_REMOVE) begin
                  count_in = count_ff - CW'(1);
                  if (low_ff) begin
                     head_in = (head_ff == AW'(CAPACITY - 1)) ? '0 : (head_ff + AW'(1));
                  end
                  state_in = S_DONE;
               end else begin
                  state_in = S_WRVAL;
               end
            end else begin
               state_in = S_READ;
            end
         end

         S_READ: begin
            state_in = S_MOVE;
         end

         S_MOVE: begin
            // destination follows the source one step
            dst_in   = src_pos;
            state_in = S_TEST;
         end

         S_WRVAL: begin
            if (op_ff == OP_INSERT) begin
               count_in = count_ff + CW'(1);
            end
            state_in = S_DONE;
         end

         S_GETRD: begin
            state_in = S_DONE;
         end

         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in      = 1'b1;
               rsp_read_value_in = rd_ok_ff ? mem_rd_ff : '0;
               rsp_status_in     = status_ff;
               rsp_count_in      = count_ff;
               state_in          = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff             <= op_in;
      idx_ff            <= idx_in;
      val_ff            <= val_in;
      dst_ff            <= dst_in;
      end_ff            <= end_in;
      up_ff             <= up_in;
      low_ff            <= low_in;
      status_ff         <= status_in;
      rd_ok_ff          <= rd_ok_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_count_ff      <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------

   // element count moves by at most one per cycle
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((count_ff == $past(count_ff)) ||
                (count_ff == $past(count_ff) + CW'(1)) ||
                (count_ff == $past(count_ff) - CW'(1))))
      else $error("element count jumped by more than one");

   // a full rejection is only reported when the store is at capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_FULL)) |-> (rsp_count_ff == CW'(CAPACITY)))
      else $error("full status reported below capacity");

   // an accepted request keeps the sequencer busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request accepted without the sequencer going busy");

endmodule
